// File: rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared widths, constants, types and the digit-to-ASCII mapping for the
// radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int VALUE_BITS = 31;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int RADIX_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;

   typedef logic [DIGIT_W-1:0]    digit_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input digit_type d);
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + {3'b000, d};
      end else begin
         return CHAR_A + {3'b000, d - DIGIT_TEN};
      end
   endfunction

endpackage

// File: rtl/rdc_divider.sv
// ----------------------------------------------------------------------------
// rdc_divider
// Bit-serial restoring divider: one quotient bit per cycle, for division by
// a base of at most sixteen.
// ----------------------------------------------------------------------------
module rdc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  rdc_pkg::value_type             dividend,
   input  logic [rdc_pkg::RADIX_W-1:0]    base,
   output rdc_pkg::value_type             quotient,
   output rdc_pkg::digit_type             remainder,
   output rdc_pkg::div_status_type        status
);
   import rdc_pkg::*;

   value_type          quo_ff, quo_in;
   digit_type          rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [RADIX_W-1:0] trial;
   logic               ge;

   // partial remainder stays below the base, so four bits plus the next bit
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign ge    = (trial >= base);

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(VALUE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = VALUE_BITS'({quo_ff, ge});
         rem_in = ge ? DIGIT_W'(trial - base) : trial[DIGIT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: rtl/rdc_digit_stack.sv
// ----------------------------------------------------------------------------
// rdc_digit_stack
// Last-in first-out shift stack of digits: remainders go in least significant
// first and come out most significant first.
// ----------------------------------------------------------------------------
module rdc_digit_stack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  rdc_pkg::digit_type            push_digit,
   input  logic                          pop,
   output rdc_pkg::digit_type            top_digit,
   output logic [rdc_pkg::CNT_W-1:0]     count
);
   import rdc_pkg::*;

   digit_type        digit_ff [VALUE_BITS];
   digit_type        digit_in [VALUE_BITS];
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      for (int i = 0; i < VALUE_BITS; i++) begin
         digit_in[i] = digit_ff[i];
      end
      count_in = count_ff;
      if (push) begin
         digit_in[0] = push_digit;
         for (int i = 1; i < VALUE_BITS; i++) begin
            digit_in[i] = digit_ff[i-1];
         end
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         for (int i = 0; i < VALUE_BITS - 1; i++) begin
            digit_in[i] = digit_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < VALUE_BITS; i++) begin
         digit_ff[i] <= digit_in[i];
      end
   end

   assign top_digit = digit_ff[0];
   assign count     = count_ff;

endmodule

// File: rtl/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts one unsigned integer per item into ASCII digits of a programmable
// base, most significant digit first, with a last flag on the final digit.
// ----------------------------------------------------------------------------
// One item is converted at a time. A bit-serial divider produces one digit
// per division, and the result then streams out of the digit stack at one
// digit per cycle when the output side does not stall. Zero gives the single
// digit '0'. The radix register resets to 10; values 0 and 1 act as 2 and
// values above 16 act as 16. Write the radix only while the block is idle.
module radix_digit_converter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [rdc_pkg::RADIX_W-1:0]   csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rdc_pkg::value_type            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rdc_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                          rsp_last_digit
);
   import rdc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [RADIX_W-1:0] base;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_accept;
   logic               div_start;
   value_type          div_dividend;
   value_type          div_quotient;
   digit_type          div_remainder;
   div_status_type     div_status;

   logic               stk_push;
   logic               stk_pop;
   digit_type          stk_top;
   logic [CNT_W-1:0]   stk_count;
   logic               out_free;

   assign radix_in = csr_write_enable ? csr_write_data : radix_ff;
   assign base     = (radix_ff < RADIX_MIN) ? RADIX_MIN :
                     (radix_ff > RADIX_MAX) ? RADIX_MAX : radix_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // keep dividing until the quotient runs out
   assign stk_push     = (state_ff == ST_DIV) && div_status.done;
   assign div_start    = req_accept || (stk_push && (div_quotient != '0));
   assign div_dividend = req_accept ? req_value : div_quotient;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign stk_pop  = (state_ff == ST_EMIT) && (stk_count != '0) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stk_push && (div_quotient == '0)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stk_pop) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_char(stk_top);
               rsp_last_in  = (stk_count == CNT_W'(1));
            end else if (stk_count == '0 && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   rdc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .base      (base),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   rdc_digit_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .push       (stk_push),
      .push_digit (div_remainder),
      .pop        (stk_pop),
      .top_digit  (stk_top),
      .count      (stk_count)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stk_push |-> (stk_count < CNT_W'(VALUE_BITS)))
      else $error("digit stack overflow");

   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_digit) |-> (stk_count == '0))
      else $error("last digit shown with digits left");

   a_emit_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!div_status.busy && !stk_push))
      else $error("divider active during emit");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_EMIT))
      else $error("item shown outside emit");

endmodule
